[rtl/wms_pkg.sv]
`default_nettype none

package wms_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned CountOutW = 7;

  localparam logic [0:0] RegInputPresorted = 1'b0;

  typedef enum logic [1:0] {
    CellHold    = 2'd0,
    CellLoad    = 2'd1,
    CellShiftUp = 2'd2,
    CellShiftDn = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     clear;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StFill  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage

`default_nettype wire

[rtl/window_median_sorter.sv]
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid_i, in_stall_o, sample_i, last_i  | in
// output   | out_valid_o, out_stall_i, median_o,       | out
//          | sample_count_o, overflow_o                |
// config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//          | prdata, pready                            |
//
// an item is written into the cell row in the cycle it is accepted: in order,
// or behind the kept items when presorted input is set; it is dropped if the row is full
// after an item marked last the row shifts down until the middle item, or for an
// even kept count the middle pair, reaches the first two cells
// reset empties the row, count and drop flag; no clearing pass
// input stalls while the row drains, and a last item stalls while a result waits
`default_nettype none

module window_median_sorter #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [wms_pkg::SampleW-1:0] sample_i,
  input  wire logic                               last_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [wms_pkg::SampleW-1:0]      median_o,
  output logic [wms_pkg::CountOutW-1:0]           sample_count_o,
  output logic                                    overflow_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int unsigned CntW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DrainW = $clog2(MAX_SAMPLES);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  logic presorted_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == wms_pkg::RegInputPresorted);
  assign prdata = (paddr[2] == wms_pkg::RegInputPresorted) ? {31'b0, presorted_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presorted_q <= 1'b0;
    end else if (cfg_wr) begin
      presorted_q <= pwdata[0];
    end
  end

  wms_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              dropped_q, dropped_d;
  logic [DrainW-1:0] drain_q, drain_d;
  logic              odd_q, odd_d;
  logic [CntW-1:0]   n_q, n_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic signed [wms_pkg::SampleW-1:0] median_q, median_d;

  logic in_acc, out_acc, has_room, finish;
  logic [CntW-1:0] n_new;
  logic [CntW-1:0] n_new_m1;

  logic signed [wms_pkg::SampleW-1:0] vals [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] occ, ins, found;
  wms_pkg::cell_ctrl_t    ctrl [MAX_SAMPLES];

  logic signed [wms_pkg::SampleW:0] pair_sum;

  assign in_stall_o = (state_q != wms_pkg::StFill) || (out_valid_q && last_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign has_room   = fill_q < MaxCnt;
  assign n_new      = has_room ? fill_q + CntW'(1) : fill_q;
  assign n_new_m1   = n_new - CntW'(1);
  assign finish     = (state_q == wms_pkg::StDrain) && (drain_q == '0);

  // cells at and after the first one in front of which the item goes, as a prefix OR over the row
  assign found[0] = ins[0];
  for (genvar g = 1; g < MAX_SAMPLES; g++) begin : g_found
    assign found[g] = found[g-1] | ins[g];
  end

  for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
    logic signed [wms_pkg::SampleW-1:0] prev_val, next_val;
    logic prev_occ, prev_found;

    if (g == 0) begin : g_first
      assign prev_val   = '0;
      assign prev_occ   = 1'b0;
      assign prev_found = 1'b0;
    end else begin : g_mid
      assign prev_val   = vals[g-1];
      assign prev_occ   = occ[g-1];
      assign prev_found = found[g-1];
    end

    if (g == MAX_SAMPLES - 1) begin : g_end
      assign next_val = '0;
    end else begin : g_nxt
      assign next_val = vals[g+1];
    end

    always_comb begin
      ctrl[g].op    = wms_pkg::CellHold;
      ctrl[g].clear = finish;
      if (in_acc && has_room) begin
        if (prev_found) begin
          ctrl[g].op = wms_pkg::CellShiftUp;
        end else if (ins[g]) begin
          ctrl[g].op = wms_pkg::CellLoad;
        end
      end else if ((state_q == wms_pkg::StDrain) && (drain_q != '0)) begin
        ctrl[g].op = wms_pkg::CellShiftDn;
      end
    end

    wms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[g]),
      .presorted_i (presorted_q),
      .new_val_i   (sample_i),
      .prev_val_i  (prev_val),
      .prev_occ_i  (prev_occ),
      .next_val_i  (next_val),
      .val_o       (vals[g]),
      .occ_o       (occ[g]),
      .ins_o       (ins[g])
    );
  end

  assign pair_sum = {vals[0][wms_pkg::SampleW-1], vals[0]}
                  + {vals[1][wms_pkg::SampleW-1], vals[1]};

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    dropped_d   = dropped_q;
    drain_d     = drain_q;
    odd_d       = odd_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    median_d    = median_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      wms_pkg::StFill: begin
        if (in_acc) begin
          fill_d    = n_new;
          dropped_d = dropped_q | !has_room;
          if (last_i) begin
            state_d = wms_pkg::StDrain;
            n_d     = n_new;
            odd_d   = n_new[0];
            ovf_d   = dropped_q | !has_room;
            drain_d = DrainW'(n_new_m1 >> 1);
          end
        end
      end
      wms_pkg::StDrain: begin
        if (drain_q == '0) begin
          median_d    = odd_q ? vals[0] : pair_sum[wms_pkg::SampleW:1];
          out_valid_d = 1'b1;
          fill_d      = '0;
          dropped_d   = 1'b0;
          state_d     = wms_pkg::StFill;
        end else begin
          drain_d = drain_q - DrainW'(1);
        end
      end
      default: begin
        state_d = wms_pkg::StFill;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wms_pkg::StFill;
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dropped_q   <= dropped_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odd_q    <= odd_d;
    n_q      <= n_d;
    ovf_q    <= ovf_d;
    median_q <= median_d;
  end

  logic [CntW+wms_pkg::CountOutW-1:0] n_ext;
  assign n_ext = {{wms_pkg::CountOutW{1'b0}}, n_q};

  assign out_valid_o    = out_valid_q;
  assign median_o       = median_q;
  assign sample_count_o = n_ext[wms_pkg::CountOutW-1:0];
  assign overflow_o     = ovf_q;

endmodule

`default_nettype wire

[rtl/wms_cell.sv]
`default_nettype none

module wms_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire wms_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic                              presorted_i,
  input  wire logic signed [wms_pkg::SampleW-1:0] new_val_i,
  input  wire logic signed [wms_pkg::SampleW-1:0] prev_val_i,
  input  wire logic                              prev_occ_i,
  input  wire logic signed [wms_pkg::SampleW-1:0] next_val_i,
  output logic signed [wms_pkg::SampleW-1:0]      val_o,
  output logic                                   occ_o,
  output logic                                   ins_o
);

  logic signed [wms_pkg::SampleW-1:0] val_q, val_d;
  logic                               occ_q, occ_d;

  // new item goes in front of this cell
  assign ins_o = !occ_q || (!presorted_i && (val_q > new_val_i));

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    case (ctrl_i.op)
      wms_pkg::CellHold: begin
      end
      wms_pkg::CellLoad: begin
        val_d = new_val_i;
        occ_d = 1'b1;
      end
      wms_pkg::CellShiftUp: begin
        val_d = prev_val_i;
        occ_d = prev_occ_i;
      end
      wms_pkg::CellShiftDn: begin
        val_d = next_val_i;
      end
      default: begin
      end
    endcase
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;

endmodule

`default_nettype wire
